FILE: sv/isa_pkg.sv
// shared types and constants for the indexed shift array
package isa_pkg;

   // width of the index and count fields carried in the cell control group
   localparam int IDX_W = 11;
   localparam int WORD_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH    = 3'd0,
      OP_POP     = 3'd1,
      OP_DEQUEUE = 3'd2,
      OP_INSERT  = 3'd3,
      OP_DELETE  = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_BADINDEX = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // broadcast from the control logic to every cell
   typedef struct packed {
      logic             push_en;
      logic             ins_en;
      logic             del_en;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] count;
   } cell_ctrl_type;

endpackage

FILE: sv/isa_cell.sv
// one storage cell of the shift array, loads, shifts up or shifts down
module isa_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  isa_pkg::cell_ctrl_type            ctrl,
   input  logic signed [isa_pkg::WORD_W-1:0] value,
   input  logic signed [isa_pkg::WORD_W-1:0] left_data,
   input  logic signed [isa_pkg::WORD_W-1:0] right_data,
   output logic signed [isa_pkg::WORD_W-1:0] data
);

   localparam logic [isa_pkg::IDX_W-1:0] K   = isa_pkg::IDX_W'(INDEX);
   localparam logic [isa_pkg::IDX_W-1:0] KP1 = isa_pkg::IDX_W'(INDEX + 1);

   logic signed [isa_pkg::WORD_W-1:0] data_ff;
   logic signed [isa_pkg::WORD_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.push_en) begin
         if (K == ctrl.count) data_in = value;
      end else if (ctrl.ins_en) begin
         if (K == ctrl.pos) begin
            data_in = value;
         end else if (K > ctrl.pos && K <= ctrl.count) begin
            data_in = left_data;
         end
      end else if (ctrl.del_en) begin
         if (K >= ctrl.pos && KP1 < ctrl.count) data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: sv/indexed_shift_array.sv
// top level of the indexed shift array: control, count, cell row and response register
// the response to an accepted request is held in the output register from the next cycle
// throughput: one request per cycle while the response is taken; every cell compares its index and shifts at once
// a stalled response holds the output register and blocks new requests until taken
// reset clears the count and the response valid; cell contents stay undefined until written
// only cells below the count are ever read, so no clearing pass is needed
module indexed_shift_array #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: operation [2:0], position [7:3], value [39:8]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // response: status [1:0], removed_value [33:2], count_after [38:34], zero [39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);

   // count must hold DEPTH itself
   localparam int CW = $clog2(DEPTH + 1);
   // address width into the cell row
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // comparison width covering both count and the 5-bit position
   localparam int IW = (CW > 5) ? CW : 5;

   // request fields
   isa_pkg::op_type                   req_op;
   logic [4:0]                        req_pos;
   logic signed [isa_pkg::WORD_W-1:0] req_value;

   assign req_op    = isa_pkg::op_type'(req_tdata[2:0]);
   assign req_pos   = req_tdata[7:3];
   assign req_value = req_tdata[39:8];

   // live count and response register
   logic [CW-1:0]                     count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   isa_pkg::status_type               status_ff, status_in;
   logic signed [isa_pkg::WORD_W-1:0] removed_ff, removed_in;
   logic [4:0]                        count_after_ff, count_after_in;

   logic                              accept;
   logic                              empty, full;
   logic [IW-1:0]                     pos_ext, count_ext;
   logic [CW-1:0]                     tail_idx;
   isa_pkg::cell_ctrl_type            ctrl;

   // cell row taps
   logic signed [isa_pkg::WORD_W-1:0] cell_q [DEPTH];

   // the response register frees the request side as soon as it is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign pos_ext   = IW'(req_pos);
   assign count_ext = IW'(count_ff);
   assign tail_idx  = count_ff - CW'(1);

   // decode one request into the cell broadcast, next count and response
   always_comb begin
      ctrl.push_en = 1'b0;
      ctrl.ins_en  = 1'b0;
      ctrl.del_en  = 1'b0;
      ctrl.pos     = isa_pkg::IDX_W'(req_pos);
      ctrl.count   = isa_pkg::IDX_W'(count_ff);
      count_in     = count_ff;
      status_in    = isa_pkg::ST_OK;
      removed_in   = '0;
      case (req_op)
         isa_pkg::OP_PUSH: begin
            if (full) begin
               status_in = isa_pkg::ST_FULL;
            end else begin
               ctrl.push_en = 1'b1;
               count_in     = count_ff + CW'(1);
            end
         end
         isa_pkg::OP_POP: begin
            if (empty) begin
               status_in  = isa_pkg::ST_EMPTY;
               removed_in = '1;
            end else begin
               // tail word comes straight out, no cell moves
               removed_in = cell_q[tail_idx[AW-1:0]];
               count_in   = tail_idx;
            end
         end
         isa_pkg::OP_DEQUEUE: begin
            if (empty) begin
               status_in  = isa_pkg::ST_EMPTY;
               removed_in = '1;
            end else begin
               // head removal is a delete at index zero
               removed_in  = cell_q[0];
               ctrl.del_en = 1'b1;
               ctrl.pos    = '0;
               count_in    = tail_idx;
            end
         end
         isa_pkg::OP_INSERT: begin
            // an index past the tail is checked before fullness
            if (pos_ext > count_ext) begin
               status_in = isa_pkg::ST_BADINDEX;
            end else if (full) begin
               status_in = isa_pkg::ST_FULL;
            end else begin
               ctrl.ins_en = 1'b1;
               count_in    = count_ff + CW'(1);
            end
         end
         isa_pkg::OP_DELETE: begin
            // empty is checked before the index
            if (empty) begin
               status_in = isa_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               status_in = isa_pkg::ST_BADINDEX;
            end else begin
               ctrl.del_en = 1'b1;
               count_in    = tail_idx;
            end
         end
         isa_pkg::OP_CLEAR: begin
            // stored words remain but are out of reach
            count_in = '0;
         end
         default: begin
            // unused codes leave everything as it is
         end
      endcase
      // cells only move on an accepted request
      if (!accept) begin
         ctrl.push_en = 1'b0;
         ctrl.ins_en  = 1'b0;
         ctrl.del_en  = 1'b0;
      end
   end

   // low five bits of the new count
   logic [IW-1:0] count_in_ext;
   assign count_in_ext   = IW'(count_in);
   assign count_after_in = count_in_ext[4:0];

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) count_ff <= count_in;
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         removed_ff     <= removed_in;
         count_after_ff <= count_after_in;
      end
   end

   // row of cells, each sees its neighbors on both sides, with zero beyond either end
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [isa_pkg::WORD_W-1:0] left_d, right_d;
         if (g == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_left
            assign left_d = cell_q[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_right
            assign right_d = cell_q[g+1];
         end
         isa_cell #(
            .INDEX(g)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .value      (req_value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[g])
         );
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, count_after_ff, removed_ff, status_ff};

endmodule

FILE: sv/isa_checker.sv
// port-level checks for the indexed shift array and their binding
module isa_checker #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   logic [1:0]  rsp_status;
   logic [31:0] rsp_removed;
   logic [4:0]  rsp_count;
   logic [4:0]  depth_low;

   assign rsp_status  = rsp_tdata[1:0];
   assign rsp_removed = rsp_tdata[33:2];
   assign rsp_count   = rsp_tdata[38:34];
   assign depth_low   = 5'(DEPTH);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // an empty status always reports an empty array
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == isa_pkg::ST_EMPTY |-> rsp_count == 5'd0)
      else $error("empty status with nonzero count");

   // a refused push or insert leaves the array full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == isa_pkg::ST_FULL |-> rsp_count == depth_low)
      else $error("full status with count below depth");

   // full and bad-index refusals never carry a removed word
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == isa_pkg::ST_FULL || rsp_status == isa_pkg::ST_BADINDEX)
      |-> rsp_removed == 32'd0)
      else $error("refused request reports a removed word");

   // a request taken on an idle output shows up in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

endmodule

bind indexed_shift_array isa_checker #(
   .DEPTH(DEPTH)
) u_isa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/tb.sv
// self-checking testbench for the indexed shift array
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH = 16;
   // generous cycle budget: about 1950 requests with random gaps and stalls
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 475;
   localparam int BURST_LEN = 40;
   // codes outside the operation set; the block must answer ok and change nothing
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;
   // traffic shaping for the random bursts
   localparam int MODE_GROW = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIXED = 2;
   // idle and stall percentages per phase: none, sender, receiver, both
   localparam int SEND_IDLE [4] = '{0, 61, 0, 9};
   localparam int RECV_STALL [4] = '{0, 0, 61, 9};

   typedef struct packed {
      logic [2:0]  op;
      logic [4:0]  pos;
      logic [31:0] value;
   } array_req_type;

   typedef struct packed {
      isa_pkg::status_type status;
      logic [31:0]         removed;
      logic [4:0]          count;
   } array_rsp_type;

   // one row of the directed stimulus; reps > 1 repeats the request with the value counting up
   typedef struct packed {
      logic [2:0]          op;
      logic [4:0]          pos;
      logic [31:0]         value;
      logic [4:0]          reps;
      logic                typed;
      isa_pkg::status_type status;
      logic [31:0]         removed;
      logic [4:0]          count;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // request: operation [2:0], position [7:3], value [39:8]
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // response: status [1:0], removed_value [33:2], count_after [38:34], zero [39]
   logic [39:0] rsp_tdata;

   // shadow copy of the array contents and occupancy
   logic [31:0] word_store [DEPTH];
   int          fill_count;
   int          peak_fill;

   array_rsp_type pending_results [$];
   int            send_idle_pct;
   int            recv_stall_pct;
   int            mismatch_count;
   int            requests_sent;
   int            responses_checked;
   int            full_refusals;
   int            empty_answers;
   int            badindex_answers;
   int            cycle_count;

   // directed part: empty-array refusals, extremes, every operation, then the full case
   plan_row_type directed_plan [25] = '{
      // empty array: pop and dequeue answer -1, delete checks emptiness before the index
      '{isa_pkg::OP_POP, 5'd0, 32'd0, 5'd1, 1'b1, isa_pkg::ST_EMPTY, 32'hffff_ffff, 5'd0},
      '{isa_pkg::OP_DEQUEUE, 5'd0, 32'd0, 5'd1, 1'b1, isa_pkg::ST_EMPTY, 32'hffff_ffff, 5'd0},
      '{isa_pkg::OP_DELETE, 5'd0, 32'd0, 5'd1, 1'b1, isa_pkg::ST_EMPTY, 32'd0, 5'd0},
      '{isa_pkg::OP_DELETE, 5'd31, 32'd0, 5'd1, 1'b1, isa_pkg::ST_EMPTY, 32'd0, 5'd0},
      // insert past the tail
      '{isa_pkg::OP_INSERT, 5'd1, 32'd5, 5'd1, 1'b1, isa_pkg::ST_BADINDEX, 32'd0, 5'd0},
      '{isa_pkg::OP_INSERT, 5'd31, 32'd5, 5'd1, 1'b1, isa_pkg::ST_BADINDEX, 32'd0, 5'd0},
      // extreme words, insert at the head and at the tail
      '{isa_pkg::OP_PUSH, 5'd0, 32'h7fff_ffff, 5'd1, 1'b1, isa_pkg::ST_OK, 32'd0, 5'd1},
      '{isa_pkg::OP_PUSH, 5'd0, 32'h8000_0000, 5'd1, 1'b1, isa_pkg::ST_OK, 32'd0, 5'd2},
      '{isa_pkg::OP_INSERT, 5'd0, 32'hffff_ffff, 5'd1, 1'b1, isa_pkg::ST_OK, 32'd0, 5'd3},
      '{isa_pkg::OP_INSERT, 5'd3, 32'd0, 5'd1, 1'b1, isa_pkg::ST_OK, 32'd0, 5'd4},
      // delete at the count is past the tail
      '{isa_pkg::OP_DELETE, 5'd4, 32'd0, 5'd1, 1'b1, isa_pkg::ST_BADINDEX, 32'd0, 5'd4},
      '{isa_pkg::OP_INSERT, 5'd1, 32'ha5a5_a5a5, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{isa_pkg::OP_DELETE, 5'd2, 32'd0, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{isa_pkg::OP_DEQUEUE, 5'd0, 32'd0, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{isa_pkg::OP_POP, 5'd0, 32'd0, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      // unknown operation codes
      '{OP_UNUSED_A, 5'd31, 32'hffff_ffff, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{OP_UNUSED_B, 5'd0, 32'd0, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{isa_pkg::OP_CLEAR, 5'd0, 32'd0, 5'd1, 1'b1, isa_pkg::ST_OK, 32'd0, 5'd0},
      // fill to capacity, then every refusal of a full array
      '{isa_pkg::OP_PUSH, 5'd0, 32'h1000_0000, 5'd16, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{isa_pkg::OP_PUSH, 5'd0, 32'd1, 5'd1, 1'b1, isa_pkg::ST_FULL, 32'd0, 5'd16},
      '{isa_pkg::OP_INSERT, 5'd16, 32'd1, 5'd1, 1'b1, isa_pkg::ST_FULL, 32'd0, 5'd16},
      // past the tail wins over full
      '{isa_pkg::OP_INSERT, 5'd17, 32'd1, 5'd1, 1'b1, isa_pkg::ST_BADINDEX, 32'd0, 5'd16},
      '{isa_pkg::OP_INSERT, 5'd0, 32'd1, 5'd1, 1'b1, isa_pkg::ST_FULL, 32'd0, 5'd16},
      // delete the last slot of the full array, then the first slot
      '{isa_pkg::OP_DELETE, 5'd15, 32'd0, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0},
      '{isa_pkg::OP_DELETE, 5'd0, 32'd0, 5'd1, 1'b0, isa_pkg::ST_OK, 32'd0, 5'd0}
   };

   indexed_shift_array #(
      .DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one request to the shadow array and returns the response it must produce
   function automatic array_rsp_type apply_array_op(array_req_type r);
      array_rsp_type p;
      int k;
      p.status = isa_pkg::ST_OK;
      p.removed = '0;
      case (r.op)
         isa_pkg::OP_PUSH: begin
            if (fill_count >= DEPTH) begin
               p.status = isa_pkg::ST_FULL;
            end else begin
               word_store[fill_count] = r.value;
               fill_count++;
            end
         end
         isa_pkg::OP_POP: begin
            if (fill_count == 0) begin
               p.status = isa_pkg::ST_EMPTY;
               p.removed = '1;
            end else begin
               fill_count--;
               p.removed = word_store[fill_count];
            end
         end
         isa_pkg::OP_DEQUEUE: begin
            if (fill_count == 0) begin
               p.status = isa_pkg::ST_EMPTY;
               p.removed = '1;
            end else begin
               p.removed = word_store[0];
               for (k = 0; k + 1 < fill_count; k++) word_store[k] = word_store[k + 1];
               fill_count--;
            end
         end
         isa_pkg::OP_INSERT: begin
            // index is checked before fullness
            if (int'(r.pos) > fill_count) begin
               p.status = isa_pkg::ST_BADINDEX;
            end else if (fill_count >= DEPTH) begin
               p.status = isa_pkg::ST_FULL;
            end else begin
               for (k = fill_count; k > int'(r.pos); k--) word_store[k] = word_store[k - 1];
               word_store[int'(r.pos)] = r.value;
               fill_count++;
            end
         end
         isa_pkg::OP_DELETE: begin
            // emptiness is checked before the index
            if (fill_count == 0) begin
               p.status = isa_pkg::ST_EMPTY;
            end else if (int'(r.pos) >= fill_count) begin
               p.status = isa_pkg::ST_BADINDEX;
            end else begin
               for (k = int'(r.pos); k + 1 < fill_count; k++) word_store[k] = word_store[k + 1];
               fill_count--;
            end
         end
         isa_pkg::OP_CLEAR: begin
            fill_count = 0;
         end
         default: begin
         end
      endcase
      if (fill_count > peak_fill) peak_fill = fill_count;
      p.count = fill_count[4:0];
      return p;
   endfunction

   // random word, with the sign and all-ones extremes mixed in
   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed requests for the current occupancy, with some noise
   function automatic array_req_type random_request(int mode);
      array_req_type r;
      int roll;
      int push_cut;
      int insert_cut;
      int pop_cut;
      int dequeue_cut;
      int delete_cut;
      case (mode)
         MODE_GROW: begin
            push_cut = 45; insert_cut = 82; pop_cut = 88; dequeue_cut = 92; delete_cut = 97;
         end
         MODE_SHRINK: begin
            push_cut = 10; insert_cut = 20; pop_cut = 45; dequeue_cut = 65; delete_cut = 95;
         end
         default: begin
            push_cut = 22; insert_cut = 44; pop_cut = 59; dequeue_cut = 74; delete_cut = 94;
         end
      endcase
      roll = $urandom_range(99);
      r.value = random_word();
      r.pos = 5'($urandom_range(31));
      if (roll < push_cut) begin
         r.op = isa_pkg::OP_PUSH;
      end else if (roll < insert_cut) begin
         r.op = isa_pkg::OP_INSERT;
         if ($urandom_range(99) < 85) r.pos = 5'($urandom_range(fill_count));
      end else if (roll < pop_cut) begin
         r.op = isa_pkg::OP_POP;
      end else if (roll < dequeue_cut) begin
         r.op = isa_pkg::OP_DEQUEUE;
      end else if (roll < delete_cut) begin
         r.op = isa_pkg::OP_DELETE;
         if (fill_count > 0 && $urandom_range(99) < 85) r.pos = 5'($urandom_range(fill_count - 1));
      end else begin
         case ($urandom_range(4))
            0: r.op = OP_UNUSED_A;
            1: r.op = OP_UNUSED_B;
            default: r.op = isa_pkg::OP_CLEAR;
         endcase
      end
      return r;
   endfunction

   // drives one request, waits for the handshake and records what the array must answer
   task automatic send_request(input array_req_type r, input logic typed,
                               input array_rsp_type typed_rsp);
      array_rsp_type expected;
      // random gap; valid stays high straight into the next request when no gap is drawn
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.value, r.pos, r.op};
      do @(posedge clock); while (!req_tready);
      expected = apply_array_op(r);
      pending_results.push_back(typed ? typed_rsp : expected);
      requests_sent++;
   endtask

   // holds the request side quiet until every outstanding response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h, expected %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_response(input logic [39:0] data);
      array_rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected response, tdata", data[31:0], 32'd0);
      end else begin
         want = pending_results.pop_front();
         responses_checked++;
         if (data[1:0] != want.status)
            report_mismatch("status", 32'(data[1:0]), 32'(want.status));
         if (data[33:2] != want.removed)
            report_mismatch("removed_value", data[33:2], want.removed);
         if (data[38:34] != want.count)
            report_mismatch("count_after", 32'(data[38:34]), 32'(want.count));
         if (data[39] != 1'b0) report_mismatch("pad bit", 32'(data[39]), 32'd0);
         case (want.status)
            isa_pkg::ST_FULL: full_refusals++;
            isa_pkg::ST_EMPTY: empty_answers++;
            isa_pkg::ST_BADINDEX: badindex_answers++;
            default: begin
            end
         endcase
      end
   endtask

   // response side: check at each handshake, then draw the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      array_req_type r;
      array_rsp_type typed_rsp;
      int mode;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      fill_count = 0;
      peak_fill = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      requests_sent = 0;
      responses_checked = 0;
      full_refusals = 0;
      empty_answers = 0;
      badindex_answers = 0;
      cycle_count = 0;
      mode = MODE_GROW;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, light idling on both sides
      send_idle_pct = 9;
      recv_stall_pct = 9;
      foreach (directed_plan[i]) begin
         for (int rep = 0; rep < int'(directed_plan[i].reps); rep++) begin
            r.op = directed_plan[i].op;
            r.pos = directed_plan[i].pos;
            r.value = directed_plan[i].value + rep;
            typed_rsp.status = directed_plan[i].status;
            typed_rsp.removed = directed_plan[i].removed;
            typed_rsp.count = directed_plan[i].count;
            send_request(r, directed_plan[i].typed, typed_rsp);
         end
      end
      // pause until the array has answered everything
      drain_responses();

      // random bursts, each with a traffic mode drawn from grow, shrink or mixed, one idling pattern per phase
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = SEND_IDLE[ph];
         recv_stall_pct = RECV_STALL[ph];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % BURST_LEN == 0) mode = $urandom_range(MODE_MIXED);
            r = random_request(mode);
            send_request(r, 1'b0, typed_rsp);
         end
         drain_responses();
      end

      // everything is back; keep watching the output register for anything stray
      repeat (4) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, peak occupancy %0d of %0d",
               requests_sent, responses_checked, peak_fill, DEPTH);
      $display("refusals seen: %0d full, %0d empty, %0d bad index",
               full_refusals, empty_answers, badindex_answers);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
